>>> hdl/hlsrgb_pkg.sv
// Shared types and constants for the HLS to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

package hlsrgb_pkg;

  // Default full-scale value of hue, luminance and saturation.
  localparam int HLS_MAX_DEF = 240;
  localparam int RGB_TOP     = 255;

  // Width of one input or output field.
  localparam int FLD_W = 8;
  // Width of a level (hi, lo, ramp) on the HLS scale.
  localparam int LVL_W = 9;
  // Width of every dividend fed to a constant divider.
  localparam int NUM_W = 17;

  typedef struct packed {
    logic [FLD_W-1:0] hue;
    logic [FLD_W-1:0] luminance;
    logic [FLD_W-1:0] saturation;
  } in_item_t;

  typedef struct packed {
    logic [FLD_W-1:0] red;
    logic [FLD_W-1:0] green;
    logic [FLD_W-1:0] blue;
  } out_item_t;

  // Levels shared by the three channel ramps.
  typedef struct packed {
    logic [LVL_W-1:0] lo;
    logic [LVL_W-1:0] hi;
    logic [LVL_W-1:0] diff;
  } levels_t;

endpackage

`default_nettype wire

>>> hdl/hlsrgb_cdiv.sv
// Two-stage pipelined division of an unsigned value by a constant.
`timescale 1ns / 1ps
`default_nettype none

module hlsrgb_cdiv #(
  parameter int DIVISOR = 2
) (
  input  wire logic                         clk,
  input  wire logic [hlsrgb_pkg::NUM_W-1:0] x,
  output logic      [hlsrgb_pkg::NUM_W-1:0] quo,
  output logic      [hlsrgb_pkg::NUM_W-1:0] rem
);
  import hlsrgb_pkg::*;

  // floor(2^NUM_W / DIVISOR): the estimate is exact or one short for any x.
  localparam logic [NUM_W:0] RECIP = (NUM_W + 1)'((2 ** NUM_W) / DIVISOR);

  logic [2*NUM_W:0]   prod_r;
  logic [NUM_W-1:0]   x_r;
  logic [NUM_W-1:0]   q_est;
  logic [NUM_W-1:0]   r_est;
  logic [NUM_W-1:0]   quo_nxt;
  logic [NUM_W-1:0]   rem_nxt;
  logic [NUM_W-1:0]   quo_r;
  logic [NUM_W-1:0]   rem_r;

  always_comb begin
    q_est = prod_r[2*NUM_W-1:NUM_W];
    r_est = x_r - q_est * NUM_W'(DIVISOR);
    if (r_est >= NUM_W'(DIVISOR)) begin
      quo_nxt = q_est + NUM_W'(1);
      rem_nxt = r_est - NUM_W'(DIVISOR);
    end else begin
      quo_nxt = q_est;
      rem_nxt = r_est;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= (2*NUM_W + 1)'(x) * (2*NUM_W + 1)'(RECIP);
    x_r    <= x;
    quo_r  <= quo_nxt;
    rem_r  <= rem_nxt;
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

`default_nettype wire

>>> hdl/hlsrgb_chan.sv
// One color channel: hue ramp, rounding and rescale to 8 bits (six stages).
`timescale 1ns / 1ps
`default_nettype none

module hlsrgb_chan #(
  parameter int HLS_MAX = hlsrgb_pkg::HLS_MAX_DEF
) (
  input  wire logic                         clk,
  input  wire hlsrgb_pkg::levels_t          lvl,
  input  wire logic [hlsrgb_pkg::FLD_W-1:0] hoff,
  output logic      [hlsrgb_pkg::FLD_W-1:0] level
);
  import hlsrgb_pkg::*;

  localparam int HALF       = HLS_MAX / 2;
  localparam int SIXTH      = HLS_MAX / 6;
  localparam int TWELFTH    = HLS_MAX / 12;
  localparam int TWO_THIRDS = (HLS_MAX * 2) / 3;

  logic [LVL_W-1:0] base_nxt;
  logic             use_nxt;
  logic [FLD_W-1:0] mul_nxt;
  logic [LVL_W-1:0] base_r;
  logic             use_r;
  logic [NUM_W-1:0] num_r;
  logic [LVL_W-1:0] base_d1_r;
  logic [LVL_W-1:0] base_d2_r;
  logic             use_d1_r;
  logic             use_d2_r;
  logic [NUM_W-1:0] ramp_q;
  logic [LVL_W-1:0] ramp;
  logic [NUM_W-1:0] fnum_r;
  logic [NUM_W-1:0] byte_q;

  // Pick the ramp segment for this hue offset.
  always_comb begin
    base_nxt = lvl.lo;
    use_nxt  = 1'b0;
    mul_nxt  = '0;
    if (hoff < FLD_W'(SIXTH)) begin
      use_nxt = 1'b1;
      mul_nxt = hoff;
    end else if (hoff < FLD_W'(HALF)) begin
      base_nxt = lvl.hi;
    end else if (hoff < FLD_W'(TWO_THIRDS)) begin
      use_nxt = 1'b1;
      mul_nxt = FLD_W'(TWO_THIRDS) - hoff;
    end
  end

  always_ff @(posedge clk) begin
    base_r    <= base_nxt;
    use_r     <= use_nxt;
    num_r     <= NUM_W'(lvl.diff) * NUM_W'(mul_nxt) + NUM_W'(TWELFTH);
    base_d1_r <= base_r;
    base_d2_r <= base_d1_r;
    use_d1_r  <= use_r;
    use_d2_r  <= use_d1_r;
    fnum_r    <= NUM_W'(ramp) * NUM_W'(RGB_TOP) + NUM_W'(HALF);
  end

  hlsrgb_cdiv #(.DIVISOR(SIXTH)) u_div_ramp (
    .clk (clk),
    .x   (num_r),
    .quo (ramp_q),
    .rem ()
  );

  assign ramp = base_d2_r + (use_d2_r ? ramp_q[LVL_W-1:0] : LVL_W'(0));

  hlsrgb_cdiv #(.DIVISOR(HLS_MAX)) u_div_scale (
    .clk (clk),
    .x   (fnum_r),
    .quo (byte_q),
    .rem ()
  );

  // Saturate at full scale.
  assign level = (byte_q > NUM_W'(RGB_TOP)) ? FLD_W'(RGB_TOP) : byte_q[FLD_W-1:0];

endmodule

`default_nettype wire

>>> hdl/hls_to_rgb_converter_core.sv
// Top level of the pipelined HLS to RGB converter.
`timescale 1ns / 1ps
`default_nettype none

// Converts one hue, luminance, saturation triple (full scale HLS_MAX, default
// 240) into 8-bit red, green and blue. An item is taken at every rising edge
// with start high; busy is always low, so a new item may follow in every
// cycle. Each result appears on out_item with out_valid high for exactly one
// cycle, in input order. The pipeline holds three constant dividers in
// series, two stages each, plus an input stage, a level stage, a segment
// stage, a rescale product stage and the output register. The receiver
// cannot stall the block and must take every strobe.
// Luminance and saturation above HLS_MAX are clamped, hue is reduced modulo
// HLS_MAX, and zero saturation gives grey (luminance scaled, truncated).

module hls_to_rgb_converter_core #(
  parameter int HLS_MAX = hlsrgb_pkg::HLS_MAX_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  output logic                      busy,
  input  wire hlsrgb_pkg::in_item_t in_item,
  output logic                      out_valid,
  output hlsrgb_pkg::out_item_t     out_item
);
  import hlsrgb_pkg::*;

  localparam int HALF   = HLS_MAX / 2;
  localparam int THIRD  = HLS_MAX / 3;
  // Stages inside one channel, from the level registers to its output.
  localparam int CH_LAT = 6;

  // ---------------------------------------------------------------- stage 1
  logic [FLD_W-1:0] lum_c;
  logic [FLD_W-1:0] sat_c;
  logic [LVL_W-1:0] hi_mul;
  logic             low_half;

  logic             v1_r, v2_r, v3_r, v4_r;
  logic [FLD_W-1:0] hue1_r, lum1_r, sat1_r;
  logic             low1_r, grey1_r;
  logic [NUM_W-1:0] hi_num1_r, grey_num1_r;

  // Clamp, then build the dividends for the hi level and the grey level.
  always_comb begin
    lum_c    = (in_item.luminance > FLD_W'(HLS_MAX)) ? FLD_W'(HLS_MAX) : in_item.luminance;
    sat_c    = (in_item.saturation > FLD_W'(HLS_MAX)) ? FLD_W'(HLS_MAX) : in_item.saturation;
    low_half = (lum_c <= FLD_W'(HALF));
    hi_mul   = low_half ? (LVL_W'(HLS_MAX) + LVL_W'(sat_c)) : LVL_W'(sat_c);
  end

  always_ff @(posedge clk) begin
    hue1_r      <= in_item.hue;
    lum1_r      <= lum_c;
    sat1_r      <= sat_c;
    low1_r      <= low_half;
    grey1_r     <= (sat_c == '0);
    hi_num1_r   <= NUM_W'(lum_c) * NUM_W'(hi_mul) + NUM_W'(HALF);
    grey_num1_r <= NUM_W'(lum_c) * NUM_W'(RGB_TOP);
  end

  // ------------------------------------------------------- stages 2 and 3
  logic [NUM_W-1:0] hue_rem, hi_quo, grey_quo;
  logic [FLD_W-1:0] lum2_r, lum3_r, sat2_r, sat3_r;
  logic             low2_r, low3_r, grey2_r, grey3_r;

  hlsrgb_cdiv #(.DIVISOR(HLS_MAX)) u_div_hue (
    .clk (clk),
    .x   (NUM_W'(hue1_r)),
    .quo (),
    .rem (hue_rem)
  );

  hlsrgb_cdiv #(.DIVISOR(HLS_MAX)) u_div_hi (
    .clk (clk),
    .x   (hi_num1_r),
    .quo (hi_quo),
    .rem ()
  );

  hlsrgb_cdiv #(.DIVISOR(HLS_MAX)) u_div_grey (
    .clk (clk),
    .x   (grey_num1_r),
    .quo (grey_quo),
    .rem ()
  );

  // Hold the side data level with the dividers.
  always_ff @(posedge clk) begin
    lum2_r  <= lum1_r;
    lum3_r  <= lum2_r;
    sat2_r  <= sat1_r;
    sat3_r  <= sat2_r;
    low2_r  <= low1_r;
    low3_r  <= low2_r;
    grey2_r <= grey1_r;
    grey3_r <= grey2_r;
  end

  // ---------------------------------------------------------------- stage 4
  levels_t          lvl_nxt;
  logic [LVL_W:0]   hi_wide;
  logic [LVL_W-1:0] hue_r_sum, hue_b_sum;
  logic [FLD_W-1:0] hue_m;
  levels_t          lvl_r;
  logic [FLD_W-1:0] hr_r, hg_r, hb_r;
  logic             grey4_r;
  logic [FLD_W-1:0] grey_val4_r;

  always_comb begin
    // Upper half of luminance: hi = lum + sat - round(lum*sat/HLS_MAX).
    hi_wide = (LVL_W + 1)'(lum3_r) + (LVL_W + 1)'(sat3_r) - (LVL_W + 1)'(hi_quo[LVL_W-1:0]);
    lvl_nxt.hi   = low3_r ? hi_quo[LVL_W-1:0] : hi_wide[LVL_W-1:0];
    lvl_nxt.lo   = {lum3_r, 1'b0} - lvl_nxt.hi;
    lvl_nxt.diff = lvl_nxt.hi - lvl_nxt.lo;
    // Wrap the red and blue hue offsets around the circle.
    hue_m     = hue_rem[FLD_W-1:0];
    hue_r_sum = LVL_W'(hue_m) + LVL_W'(THIRD);
    hue_b_sum = LVL_W'(hue_m) + LVL_W'(HLS_MAX - THIRD);
    if (hue_r_sum >= LVL_W'(HLS_MAX)) begin
      hue_r_sum = hue_r_sum - LVL_W'(HLS_MAX);
    end
    if (hue_b_sum >= LVL_W'(HLS_MAX)) begin
      hue_b_sum = hue_b_sum - LVL_W'(HLS_MAX);
    end
  end

  always_ff @(posedge clk) begin
    lvl_r       <= lvl_nxt;
    hr_r        <= hue_r_sum[FLD_W-1:0];
    hg_r        <= hue_m;
    hb_r        <= hue_b_sum[FLD_W-1:0];
    grey4_r     <= grey3_r;
    grey_val4_r <= (grey_quo > NUM_W'(RGB_TOP)) ? FLD_W'(RGB_TOP) : grey_quo[FLD_W-1:0];
  end

  // ---------------------------------------------------- stages 5 through 10
  logic [FLD_W-1:0] red_c, green_c, blue_c;

  hlsrgb_chan #(.HLS_MAX(HLS_MAX)) u_chan_red (
    .clk   (clk),
    .lvl   (lvl_r),
    .hoff  (hr_r),
    .level (red_c)
  );

  hlsrgb_chan #(.HLS_MAX(HLS_MAX)) u_chan_green (
    .clk   (clk),
    .lvl   (lvl_r),
    .hoff  (hg_r),
    .level (green_c)
  );

  hlsrgb_chan #(.HLS_MAX(HLS_MAX)) u_chan_blue (
    .clk   (clk),
    .lvl   (lvl_r),
    .hoff  (hb_r),
    .level (blue_c)
  );

  // Carry the grey decision alongside the channel pipes.
  logic [CH_LAT-1:0] vdly_r;
  logic [CH_LAT-1:0] gdly_r;
  logic [FLD_W-1:0]  gval_dly_r [CH_LAT];

  always_ff @(posedge clk) begin
    gdly_r[0]     <= grey4_r;
    gval_dly_r[0] <= grey_val4_r;
    for (int i = 1; i < CH_LAT; i++) begin
      gdly_r[i]     <= gdly_r[i-1];
      gval_dly_r[i] <= gval_dly_r[i-1];
    end
  end

  // --------------------------------------------------------- output stage
  out_item_t out_nxt;
  out_item_t out_item_r;
  logic      out_valid_r;
  logic      out_grey_r;

  always_comb begin
    if (gdly_r[CH_LAT-1]) begin
      out_nxt.red   = gval_dly_r[CH_LAT-1];
      out_nxt.green = gval_dly_r[CH_LAT-1];
      out_nxt.blue  = gval_dly_r[CH_LAT-1];
    end else begin
      out_nxt.red   = red_c;
      out_nxt.green = green_c;
      out_nxt.blue  = blue_c;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_nxt;
    out_grey_r <= gdly_r[CH_LAT-1];
  end

  // Advance the valid bits; reset drops every item in flight.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      vdly_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= start;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      vdly_r      <= {vdly_r[CH_LAT-2:0], v4_r};
      out_valid_r <= vdly_r[CH_LAT-1];
    end
  end

  assign busy      = 1'b0;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ------------------------------------------------------------ assertions
  a_item_arrives: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> ##10 out_valid_r)
    else $error("accepted item did not reach the output in time");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(v1_r, 10))
    else $error("result strobe without a matching accepted item");

  a_grey_equal: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_grey_r) |->
      (out_item_r.red == out_item_r.green) && (out_item_r.green == out_item_r.blue))
    else $error("grey result has unequal channels");

  a_hue_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r |-> (hr_r < FLD_W'(HLS_MAX)) && (hg_r < FLD_W'(HLS_MAX)) &&
             (hb_r < FLD_W'(HLS_MAX)))
    else $error("hue offset outside one turn");

endmodule

`default_nettype wire
